// ===== rtl/combination_unrank_lex_top_defines.svh =====
// Assertion macros for the combination unranking block.
`ifndef COMBINATION_UNRANK_LEX_TOP_DEFINES_SVH
`define COMBINATION_UNRANK_LEX_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define CUL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("combination_unrank_lex: assertion failed");
// Expression must never be true outside reset.
`define CUL_NEVER(lbl, expr) \
  `CUL_ASSERT(lbl, !(expr))
`else
`define CUL_ASSERT(lbl, prop)
`define CUL_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/cul_pkg.sv =====
// Shared constants, types and helpers for the combination unranking block.
package cul_pkg;

  localparam int MAX_COUNT = 32;
  localparam int TAB_ROWS  = 2 * MAX_COUNT + 1;
  localparam int TAB_COLS  = MAX_COUNT + 1;
  localparam int TAB_DEPTH = TAB_ROWS * TAB_COLS;
  localparam int ADDR_W    = $clog2(TAB_DEPTH);
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int ROW_W     = $clog2(TAB_ROWS);
  localparam int CFG_W     = 6;
  localparam int RANK_W    = 30;
  localparam int IDX_W     = 2;

  localparam logic [RANK_W-1:0] SAT_LIMIT = RANK_W'(1000000000);

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_COUNT_A = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COUNT_Z = IDX_W'(1);

  typedef enum logic [6:0] {
    ST_BUILD_RD = 7'b0000001,
    ST_BUILD_WR = 7'b0000010,
    ST_IDLE     = 7'b0000100,
    ST_TOT_RD   = 7'b0001000,
    ST_TOT_CHK  = 7'b0010000,
    ST_SYM_RD   = 7'b0100000,
    ST_SYM_DEC  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    RD_BUILD = 2'd0,
    RD_TOTAL = 2'd1,
    RD_SYM   = 2'd2
  } rdsel_t;

  typedef struct packed {
    rdsel_t rd_sel;
    logic   build_wr;
    logic   load;
    logic   tot_chk;
    logic   sym_dec;
  } cmd_t;

  typedef struct packed {
    logic build_end;
    logic rank_bad;
    logic last_sym;
  } stat_t;

  function automatic logic [ADDR_W-1:0] tab_addr(input logic [ROW_W-1:0] n,
                                                 input logic [CNT_W-1:0] r);
    return ADDR_W'(n) * ADDR_W'(TAB_COLS) + ADDR_W'(r);
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] res;
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (v > CFG_W'(MAX_COUNT)) begin
      res = CNT_W'(MAX_COUNT);
    end else begin
      res = CNT_W'(v);
    end
    return res;
  endfunction

endpackage

// ===== rtl/combination_unrank_lex_top.sv =====
// Combination unranking block: walks a saturated Pascal table to spell out
// the rank-th string of count_a zeros and count_z ones in lexicographic order.
// After reset the block builds the binomial table in its RAM, a read step then
// a write step per entry over 65 rows of 33 entries, with busy high; configuration
// writes are taken throughout. An item is taken when start is high and busy is
// low. It reads the total and checks the rank against it, then handles each
// symbol with a registered table read, then compare and subtract, walking the
// clamped counts; busy stays high until the last symbol or a no-such answer.
// Each result appears in the cycle after it is decided, on
// out_valid for exactly one cycle; the receiver cannot stall and must take it.
`include "combination_unrank_lex_top_defines.svh"

module combination_unrank_lex_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [cul_pkg::RANK_W-1:0] in_rank,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cul_pkg::IDX_W-1:0]  cfg_index,
  input  logic [cul_pkg::CFG_W-1:0]  cfg_data,
  output logic                       out_valid,
  output logic                       out_symbol,
  output logic                       out_no_such,
  output logic                       out_last
);
  import cul_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  cul_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  cul_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_rank     (in_rank),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_symbol  (out_symbol),
    .out_no_such (out_no_such),
    .out_last    (out_last)
  );

  // An accepted item keeps the block busy in the following cycle.
  `CUL_ASSERT(a_start_busy, (start && !busy) |=> busy)
  // A no-such answer is always the only, and so the last, result of its item.
  `CUL_NEVER(a_no_such_last, out_valid && out_no_such && !out_last)
  // The last result of an item is never followed at once by another result.
  `CUL_ASSERT(a_last_gap, (out_valid && out_last) |=> !out_valid)
  // Results only follow a cycle in which the block was working.
  `CUL_ASSERT(a_out_after_busy, out_valid |-> $past(busy))

endmodule

// ===== rtl/cul_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cul_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cul_ctrl.sv =====
// Sequencing state machine: table build after reset, then item processing.
module cul_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cul_pkg::stat_t stat,
  output cul_pkg::cmd_t  cmd
);
  import cul_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BUILD_RD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = RD_BUILD;
    case (state_r)
      ST_BUILD_RD: begin
        state_nxt = ST_BUILD_WR;
      end
      ST_BUILD_WR: begin
        cmd.build_wr = 1'b1;
        state_nxt    = stat.build_end ? ST_IDLE : ST_BUILD_RD;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TOT_RD;
        end
      end
      ST_TOT_RD: begin
        cmd.rd_sel = RD_TOTAL;
        state_nxt  = ST_TOT_CHK;
      end
      ST_TOT_CHK: begin
        cmd.tot_chk = 1'b1;
        state_nxt   = stat.rank_bad ? ST_IDLE : ST_SYM_RD;
      end
      ST_SYM_RD: begin
        cmd.rd_sel = RD_SYM;
        state_nxt  = ST_SYM_DEC;
      end
      ST_SYM_DEC: begin
        cmd.sym_dec = 1'b1;
        state_nxt   = stat.last_sym ? ST_IDLE : ST_SYM_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/cul_dp.sv =====
// Datapath: binomial table, configuration registers, rank walk and result register.
module cul_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cul_pkg::cmd_t                cmd,
  output cul_pkg::stat_t               stat,
  input  logic [cul_pkg::RANK_W-1:0]   in_rank,
  input  logic                         cfg_valid,
  input  logic [cul_pkg::IDX_W-1:0]    cfg_index,
  input  logic [cul_pkg::CFG_W-1:0]    cfg_data,
  output logic                         out_valid,
  output logic                         out_symbol,
  output logic                         out_no_such,
  output logic                         out_last
);
  import cul_pkg::*;

  logic [CFG_W-1:0]  count_a_r, count_z_r;
  logic [ROW_W-1:0]  bn_r, bn_nxt;
  logic [CNT_W-1:0]  br_r, br_nxt;
  logic [RANK_W-1:0] prev_r;
  logic [CNT_W-1:0]  ra_r, ra_nxt, rz_r, rz_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              out_valid_r, out_symbol_r, out_no_such_r, out_last_r;

  logic [ADDR_W-1:0] raddr, waddr;
  logic [RANK_W-1:0] rdata, wdata;
  logic [RANK_W:0]   sum;
  logic [ROW_W-1:0]  rem_n;
  logic              pick_z;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= CFG_W'(1);
      count_z_r <= CFG_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_COUNT_A) begin
        count_a_r <= cfg_data;
      end else if (cfg_index == REG_COUNT_Z) begin
        count_z_r <= cfg_data;
      end
    end
  end

  // Pascal build: entry (n, r) is the saturated sum of (n-1, r) from the
  // read port and (n-1, r-1) held from the previous step.
  assign sum = {1'b0, rdata} + {1'b0, prev_r};

  always_comb begin
    if (br_r == '0) begin
      wdata = RANK_W'(1);
    end else if (bn_r == '0) begin
      wdata = '0;
    end else if (sum > {1'b0, SAT_LIMIT}) begin
      wdata = SAT_LIMIT;
    end else begin
      wdata = sum[RANK_W-1:0];
    end
  end

  assign waddr = tab_addr(bn_r, br_r);
  assign stat.build_end = (bn_r == ROW_W'(TAB_ROWS - 1)) && (br_r == CNT_W'(TAB_COLS - 1));

  always_comb begin
    bn_nxt = bn_r;
    br_nxt = br_r;
    if (cmd.build_wr && !stat.build_end) begin
      if (br_r == CNT_W'(TAB_COLS - 1)) begin
        br_nxt = '0;
        bn_nxt = bn_r + ROW_W'(1);
      end else begin
        br_nxt = br_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bn_r <= '0;
      br_r <= '0;
    end else begin
      bn_r <= bn_nxt;
      br_r <= br_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_wr) begin
      prev_r <= rdata;
    end
  end

  // Read address selection.
  assign rem_n = ROW_W'(ra_r) + ROW_W'(rz_r);

  always_comb begin
    case (cmd.rd_sel)
      RD_BUILD: raddr = (bn_r == '0) ? '0 : tab_addr(bn_r - ROW_W'(1), br_r);
      RD_TOTAL: raddr = tab_addr(rem_n, ra_r);
      RD_SYM:   raddr = (ra_r == '0) ? '0
                        : tab_addr(rem_n - ROW_W'(1), ra_r - CNT_W'(1));
      default:  raddr = '0;
    endcase
  end

  cul_ram #(
    .WIDTH (RANK_W),
    .DEPTH (TAB_DEPTH)
  ) u_tab (
    .clk   (clk),
    .we    (cmd.build_wr),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Rank walk.
  assign stat.rank_bad = (rank_r == '0) || (rank_r > rdata);
  assign stat.last_sym = (rem_n == ROW_W'(1));
  assign pick_z        = (ra_r == '0) || (rdata < rank_r);

  always_comb begin
    ra_nxt   = ra_r;
    rz_nxt   = rz_r;
    rank_nxt = rank_r;
    if (cmd.load) begin
      ra_nxt   = clamp_count(count_a_r);
      rz_nxt   = clamp_count(count_z_r);
      rank_nxt = in_rank;
    end else if (cmd.sym_dec) begin
      if (!pick_z) begin
        ra_nxt = ra_r - CNT_W'(1);
      end else begin
        if (ra_r != '0) begin
          rank_nxt = rank_r - rdata;
        end
        if (rz_r != '0) begin
          rz_nxt = rz_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_r   <= ra_nxt;
    rz_r   <= rz_nxt;
    rank_r <= rank_nxt;
  end

  // Result register: one strobe per result item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.sym_dec || (cmd.tot_chk && stat.rank_bad);
    end
  end

  always_ff @(posedge clk) begin
    out_no_such_r <= cmd.tot_chk;
    out_symbol_r  <= cmd.sym_dec && pick_z;
    out_last_r    <= cmd.tot_chk || stat.last_sym;
  end

  assign out_valid   = out_valid_r;
  assign out_symbol  = out_symbol_r;
  assign out_no_such = out_no_such_r;
  assign out_last    = out_last_r;

endmodule

// ===== test/tb_combination_unrank_lex_top.sv =====
// Self-checking testbench for the lexicographic combination unranking block.
module tb_combination_unrank_lex_top;
  import cul_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam logic [IDX_W-1:0] REG_SPARE_2 = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SPARE_3 = IDX_W'(3);
  localparam logic [RANK_W-1:0] RANK_ONES = '1;

  typedef struct packed {
    logic symbol;
    logic no_such;
    logic last;
  } spelled_t;

  class unrank_scoreboard;
    int unsigned pascal [TAB_ROWS][TAB_COLS];
    logic [CFG_W-1:0] count_a;
    logic [CFG_W-1:0] count_z;
    spelled_t spelled_q[$];
    int errors;

    function new();
      int unsigned s;
      for (int n = 0; n < TAB_ROWS; n++) begin
        for (int r = 0; r < TAB_COLS; r++) begin
          if (r > n) begin
            pascal[n][r] = 0;
          end else if (r == 0 || r == n) begin
            pascal[n][r] = 1;
          end else begin
            s = pascal[n-1][r] + pascal[n-1][r-1];
            pascal[n][r] = (s > SAT_LIMIT) ? SAT_LIMIT : s;
          end
        end
      end
      count_a = CFG_W'(1);
      count_z = CFG_W'(1);
      errors = 0;
    endfunction

    // The registers keep their raw bits; the walk uses them pulled into range.
    function int unsigned effective_count(input logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (v > CFG_W'(MAX_COUNT)) return MAX_COUNT;
      return v;
    endfunction

    function int unsigned binom(input int unsigned n, input int unsigned r);
      if (n >= TAB_ROWS || r >= TAB_COLS) return 0;
      return pascal[n][r];
    endfunction

    function int unsigned total_strings();
      int unsigned a;
      int unsigned z;
      a = effective_count(count_a);
      z = effective_count(count_z);
      return binom(a + z, a);
    endfunction

    function void write_count(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      if (idx == REG_COUNT_A) begin
        count_a = data;
      end else if (idx == REG_COUNT_Z) begin
        count_z = data;
      end
    endfunction

    // Spells out the string for one accepted rank and queues its symbols.
    function void note_rank(input logic [RANK_W-1:0] rank);
      int unsigned rem_a;
      int unsigned rem_z;
      int unsigned rem_rank;
      int unsigned c;
      spelled_t res;
      rem_a = effective_count(count_a);
      rem_z = effective_count(count_z);
      if (rank == 0 || rank > total_strings()) begin
        res.symbol = 1'b0;
        res.no_such = 1'b1;
        res.last = 1'b1;
        spelled_q.push_back(res);
        return;
      end
      rem_rank = rank;
      while (rem_a + rem_z > 0) begin
        res.no_such = 1'b0;
        if (rem_a == 0) begin
          res.symbol = 1'b1;
          rem_z--;
        end else begin
          // Strings that continue with 'a' come first; skip past them if the
          // rank lies beyond.
          c = binom(rem_a + rem_z - 1, rem_a - 1);
          if (c >= rem_rank) begin
            res.symbol = 1'b0;
            rem_a--;
          end else begin
            res.symbol = 1'b1;
            rem_rank -= c;
            if (rem_z > 0) rem_z--;
          end
        end
        res.last = (rem_a + rem_z == 0);
        spelled_q.push_back(res);
      end
    endfunction

    function int pending();
      return spelled_q.size();
    endfunction

    task report_mismatch(input string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_symbol(input logic symbol, input logic no_such, input logic last);
      spelled_t want;
      if (spelled_q.size() == 0) begin
        report_mismatch($sformatf("result %b/%b/%b with nothing outstanding",
                                  symbol, no_such, last));
        return;
      end
      want = spelled_q.pop_front();
      if (symbol !== want.symbol)
        report_mismatch($sformatf("symbol %b, expected %b", symbol, want.symbol));
      if (no_such !== want.no_such)
        report_mismatch($sformatf("no_such %b, expected %b", no_such, want.no_such));
      if (last !== want.last)
        report_mismatch($sformatf("last %b, expected %b", last, want.last));
    endtask

    task close_out();
      if (spelled_q.size() != 0)
        report_mismatch($sformatf("%0d results never came", spelled_q.size()));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [RANK_W-1:0]  in_rank;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               out_valid;
  logic               out_symbol;
  logic               out_no_such;
  logic               out_last;

  unrank_scoreboard board;
  int steady_left = 0;
  int quiet_cycles = 0;

  combination_unrank_lex_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_rank    (in_rank),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_symbol (out_symbol),
    .out_no_such(out_no_such),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) board.check_symbol(out_symbol, out_no_such, out_last);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1 || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_rank(input logic [RANK_W-1:0] rank);
    int gap;
    if (steady_left > 0) begin
      gap = 0;
      steady_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0) steady_left = $urandom_range(5, 15);
    end
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      in_rank <= RANK_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_rank <= rank;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_rank(rank);
  endtask

  // Stops issuing items and waits until every expected result has come back.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.write_count(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [RANK_W-1:0] draw_rank(input int unsigned total);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return RANK_W'($urandom_range(1, total));
    if (pick == 14) return RANK_W'(1);
    if (pick == 15) return RANK_W'(total);
    if (pick == 16) return RANK_W'(total + 1);
    if (pick == 17) return '0;
    return RANK_W'($urandom);
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] z,
                           input int items);
    int unsigned total;
    wait_idle();
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
    write_reg(REG_COUNT_A, a);
    write_reg(REG_COUNT_Z, z);
    total = board.total_strings();
    repeat (items) send_rank(draw_rank(total));
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_rank = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_COUNT_A;
    cfg_data = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Counts straight out of reset, rank zero and ranks past the end.
    send_rank('0);
    send_rank(RANK_W'(1));
    send_rank(RANK_W'(2));
    send_rank(RANK_W'(3));
    send_rank(RANK_ONES);

    // Counts of zero and of all ones, which are pulled into range.
    wait_idle();
    write_reg(REG_COUNT_A, '0);
    write_reg(REG_COUNT_Z, '1);
    send_rank(RANK_W'(1));
    send_rank(RANK_W'(17));
    send_rank(RANK_W'(33));
    send_rank(RANK_W'(34));

    // Largest counts: the total saturates at one billion.
    wait_idle();
    write_reg(REG_COUNT_A, CFG_W'(MAX_COUNT));
    write_reg(REG_COUNT_Z, CFG_W'(MAX_COUNT));
    send_rank(RANK_W'(1));
    send_rank(SAT_LIMIT);
    send_rank(SAT_LIMIT + RANK_W'(1));
    send_rank(RANK_W'(30'h2AAAAAAA));
    send_rank(RANK_W'(30'h15555555));

    // Writes to indexes beyond the register list must leave the counts alone.
    wait_idle();
    write_reg(REG_COUNT_A, CFG_W'(2));
    write_reg(REG_COUNT_Z, CFG_W'(3));
    write_reg(REG_SPARE_2, CFG_W'(5));
    write_reg(REG_SPARE_3, '1);
    send_rank(RANK_W'(5));
    send_rank(RANK_W'(10));
    send_rank(RANK_W'(11));

    run_phase(CFG_W'(1), CFG_W'(1), 20);
    run_phase(CFG_W'(3), CFG_W'(4), 35);
    run_phase(CFG_W'(32), CFG_W'(32), 12);
    run_phase(CFG_W'(10), CFG_W'(10), 25);
    run_phase(CFG_W'(0), CFG_W'(0), 12);
    run_phase(CFG_W'(63), CFG_W'(63), 8);
    run_phase(CFG_W'(1), CFG_W'(32), 25);
    run_phase(CFG_W'(32), CFG_W'(1), 25);
    run_phase(CFG_W'(20), CFG_W'(20), 15);
    repeat (3) run_phase(CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(0, 63)), 30);

    wait_idle();
    repeat (8) @(posedge clk);
    board.close_out();
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
